// File: rtl/rfdcd_pkg.sv
// Shared types and constants for the RGB frame disc/cross drawer.
// Command codes, queue word layout, result word and configuration register indexes.
// No dependencies.
package rfdcd_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int COORD_W    = 11;	// signed row/col of a command
	localparam int SUM_W      = 12;	// signed center + offset
	localparam int DIM_W      = 11;	// effective dimension, up to 511
	localparam int EXT_W      = 8;
	localparam int SPAN_W     = 9;	// walk half-size, up to 256
	localparam int OFS_W      = 10;	// signed walk offset
	localparam int LIM_W      = 17;	// squared radius, up to 65536
	localparam int COLOR_W    = 24;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_DATA_W-1:0] RST_DIM = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_DISC  = 2'd2,
		CMD_CROSS = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                kind;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic [COLOR_W-1:0]  color;
		logic [SPAN_W-1:0]   span;
		logic [LIM_W-1:0]    lim;
	} queue_word_t;

	typedef struct packed {
		logic               valid;
		logic [COLOR_W-1:0] color;
	} result_t;

endpackage

// File: rtl/rfdcd_front.sv
// Command front end: accepts a command and classifies it into a queue word.
// Computes the walk half-size and the squared disc radius. Uses rfdcd_pkg.
module rfdcd_front import rfdcd_pkg::*; (
	input  logic               start,
	input  logic               full,
	input  logic [1:0]         command,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic [CH_W-1:0]    red_in,
	input  logic [CH_W-1:0]    green_in,
	input  logic [CH_W-1:0]    blue_in,
	input  logic [EXT_W-1:0]   extent,
	output logic               push,
	output queue_word_t        word
);

	logic [SPAN_W-1:0] e_c;
	logic [SPAN_W-1:0] span_c;
	cmd_t              kind_c;

	assign kind_c = cmd_t'(command);
	assign e_c    = {1'b0, extent} + SPAN_W'(1);

	always_comb begin
		unique case (kind_c) inside
			CMD_DISC:            span_c = e_c;
			CMD_CROSS:           span_c = {1'b0, extent};
			CMD_WRITE, CMD_READ: span_c = '0;
			default:             span_c = '0;
		endcase
	end

	assign push       = start && !full;
	assign word.kind  = kind_c;
	assign word.row   = row;
	assign word.col   = col;
	assign word.color = {red_in, green_in, blue_in};
	assign word.span  = span_c;
	assign word.lim   = LIM_W'(e_c) * LIM_W'(e_c);

endmodule

// File: rtl/rfdcd_fifo.sv
// Short command queue between the front end and the drawing engine.
// Holds QUEUE_DEPTH command words. Uses rfdcd_pkg.
module rfdcd_fifo import rfdcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_word_t push_word,
	input  logic        pop,
	output logic        full,
	output logic        not_empty,
	output queue_word_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

	queue_word_t       store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign head      = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != DEPTH_C) else $error("queue pushed while full");

endmodule

// File: rtl/rfdcd_back.sv
// Drawing engine: walks each command's pixel window one pixel per cycle,
// tests disc membership and image bounds, and owns the frame memory. Uses rfdcd_pkg.
module rfdcd_back import rfdcd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  queue_word_t      q_word,
	output logic             q_pop,
	input  logic [DIM_W-1:0] eff_w,
	input  logic [DIM_W-1:0] eff_h,
	output result_t          res
);

	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW = RW + CW;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t             state_q;
	queue_word_t        cmd_q;
	logic               phase_q;
	logic [OFS_W-1:0]   i_q;
	logic [OFS_W-1:0]   j_q;
	logic [SPAN_W-1:0]  ilim_q;
	logic [SPAN_W-1:0]  jlim_q;

	logic               valid_s1;
	logic               last_s1;
	logic               inside_s1;
	logic [AW-1:0]      addr_s1;
	logic [LIM_W-1:0]   isq_s1;
	logic [LIM_W-1:0]   jsq_s1;

	logic               valid_s2;
	logic               last_s2;
	logic               we_s2;
	logic               inside_s2;
	logic [AW-1:0]      addr_s2;

	logic               last_s3;
	logic               inside_s3;
	logic [COLOR_W-1:0] rdata_q;

	logic [COLOR_W-1:0] frame_mem [2**AW];

	logic [OFS_W-1:0]   q_nspan;
	logic [OFS_W-1:0]   c_nspan;
	logic               walk_end;
	logic               two_phase;
	logic [OFS_W-1:0]   j_next;
	logic [OFS_W-1:0]   i_next;
	logic [SUM_W-1:0]   pr;
	logic [SUM_W-1:0]   pc;
	logic               inside_c;
	logic [OFS_W-1:0]   ineg;
	logic [OFS_W-1:0]   jneg;
	logic [SPAN_W-1:0]  iabs;
	logic [SPAN_W-1:0]  jabs;
	logic               hit_c;
	logic [LIM_W:0]     dist_c;

	assign q_nspan   = -{1'b0, q_word.span};
	assign c_nspan   = -{1'b0, cmd_q.span};
	assign walk_end  = (i_q == {1'b0, ilim_q}) && (j_q == {1'b0, jlim_q});
	assign two_phase = (cmd_q.kind == CMD_CROSS) && !phase_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		if (j_q == {1'b0, jlim_q}) begin
			j_next = -{1'b0, jlim_q};
			i_next = i_q + OFS_W'(1);
		end else begin
			j_next = j_q + OFS_W'(1);
			i_next = i_q;
		end
	end

	assign pr = {cmd_q.row[COORD_W-1], cmd_q.row} + {{(SUM_W-OFS_W){i_q[OFS_W-1]}}, i_q};
	assign pc = {cmd_q.col[COORD_W-1], cmd_q.col} + {{(SUM_W-OFS_W){j_q[OFS_W-1]}}, j_q};
	assign inside_c = !pr[SUM_W-1] && (pr[DIM_W-1:0] < eff_h)
		&& !pc[SUM_W-1] && (pc[DIM_W-1:0] < eff_w);

	assign ineg = -i_q;
	assign jneg = -j_q;
	assign iabs = i_q[OFS_W-1] ? ineg[SPAN_W-1:0] : i_q[SPAN_W-1:0];
	assign jabs = j_q[OFS_W-1] ? jneg[SPAN_W-1:0] : j_q[SPAN_W-1:0];

	assign dist_c = {1'b0, isq_s1} + {1'b0, jsq_s1};
	assign hit_c  = (cmd_q.kind != CMD_DISC) || (dist_c < {1'b0, cmd_q.lim});

	// sequencer and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			we_s2    <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			last_s1  <= (state_q == ST_SCAN) && walk_end && !two_phase;
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && last_s1;
			we_s2    <= valid_s1 && inside_s1 && hit_c && (cmd_q.kind != CMD_READ);
			last_s3  <= valid_s2 && last_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						phase_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (walk_end) begin
						if (two_phase) begin
							phase_q <= 1'b1;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk counters and command word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q  <= q_word;
			ilim_q <= q_word.span;
			i_q    <= q_nspan;
			if (q_word.kind == CMD_CROSS) begin
				jlim_q <= '0;
				j_q    <= '0;
			end else begin
				jlim_q <= q_word.span;
				j_q    <= q_nspan;
			end
		end else if (state_q == ST_SCAN) begin
			if (walk_end && two_phase) begin
				ilim_q <= '0;
				jlim_q <= cmd_q.span;
				i_q    <= '0;
				j_q    <= c_nspan;
			end else begin
				i_q <= i_next;
				j_q <= j_next;
			end
		end
	end

	// pixel pipeline payload
	always_ff @(posedge clk) begin
		inside_s1 <= inside_c;
		addr_s1   <= {pr[RW-1:0], pc[CW-1:0]};
		isq_s1    <= LIM_W'(iabs) * LIM_W'(iabs);
		jsq_s1    <= LIM_W'(jabs) * LIM_W'(jabs);
		inside_s2 <= inside_s1;
		addr_s2   <= addr_s1;
		inside_s3 <= inside_s2;
	end

	always_ff @(posedge clk) begin
		if (we_s2) begin
			frame_mem[addr_s2] <= cmd_q.color;
		end
		rdata_q <= frame_mem[addr_s2];
	end

	assign res.valid = last_s3;
	assign res.color = ((cmd_q.kind == CMD_READ) && inside_s3) ? rdata_q : '0;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !valid_s1 && !valid_s2 && !last_s3)
		else $error("pixel in flight while idle");
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s3 |-> state_q == ST_DRAIN) else $error("done outside drain");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		last_s3 |=> !last_s3) else $error("two done strobes in a row");
	a_pop_scan: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_SCAN) else $error("pop did not start a walk");

endmodule

// File: rtl/rgb_frame_disc_cross_drawer.sv
// Top level of the RGB frame disc/cross drawer: configuration registers,
// front end, command queue and drawing engine. Uses rfdcd_pkg, rfdcd_front,
// rfdcd_fifo, rfdcd_back.
//
//  channel   signals                                        handshake
//  command   start busy command row col red_in green_in     start & !busy
//            blue_in extent
//  result    result_valid red_out green_out blue_out        result_valid, one cycle
//            done_res
//  config    cfg_valid cfg_ready cfg_index cfg_data         cfg_valid & cfg_ready
//
// A command walks N pixels, one per cycle; its done strobe follows the last pixel through
// the s1, s2 and s3 pipeline registers, and the engine takes the next word from the queue
// only after that strobe returns it from drain to idle. N = (2*extent+3)^2 for a disc,
// 2*(2*extent+1) for a cross, 1 for a pixel write or read.
// Reset clears control state only; the frame memory is undefined until written.
// Results cannot be stalled; busy rises only when the two-word queue is full.
module rgb_frame_disc_cross_drawer import rfdcd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [COORD_W-1:0]    row,
	input  logic [COORD_W-1:0]    col,
	input  logic [CH_W-1:0]       red_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       blue_in,
	input  logic [EXT_W-1:0]      extent,
	output logic                  result_valid,
	output logic [CH_W-1:0]       red_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       blue_out,
	output logic                  done_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [DIM_W-1:0] MAXW_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAXH_D = DIM_W'(MAX_HEIGHT);

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [DIM_W-1:0]      width_x;
	logic [DIM_W-1:0]      height_x;
	logic [DIM_W-1:0]      eff_w;
	logic [DIM_W-1:0]      eff_h;

	logic                  push;
	queue_word_t           push_word;
	logic                  full;
	logic                  not_empty;
	logic                  pop;
	queue_word_t           head;
	result_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_DIM;
			height_q <= RST_DIM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign width_x  = DIM_W'(width_q);
	assign height_x = DIM_W'(height_q);
	assign eff_w    = (width_x > MAXW_D) ? MAXW_D : width_x;
	assign eff_h    = (height_x > MAXH_D) ? MAXH_D : height_x;

	assign busy = full;

	rfdcd_front u_front (
		.start    (start),
		.full     (full),
		.command  (command),
		.row      (row),
		.col      (col),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.extent   (extent),
		.push     (push),
		.word     (push_word)
	);

	rfdcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	rfdcd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_word  (head),
		.q_pop   (pop),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.res     (res)
	);

	assign result_valid = res.valid;
	assign done_res     = res.valid;
	assign red_out      = res.color[23:16];
	assign green_out    = res.color[15:8];
	assign blue_out     = res.color[7:0];

endmodule

// File: dv/rgb_frame_disc_cross_drawer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_frame_disc_cross_drawer: pixel write/read, disc and
// cross drawing against an in-bench frame model, across several image sizes.
// Depends on rfdcd_pkg and the rgb_frame_disc_cross_drawer RTL.
module rgb_frame_disc_cross_drawer_test;
	import rfdcd_pkg::*;

	localparam int FRAME_W = DEF_MAX_WIDTH;
	localparam int FRAME_H = DEF_MAX_HEIGHT;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            done;
	} pixel_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            command;
	logic [COORD_W-1:0]    row;
	logic [COORD_W-1:0]    col;
	logic [CH_W-1:0]       red_in;
	logic [CH_W-1:0]       green_in;
	logic [CH_W-1:0]       blue_in;
	logic [EXT_W-1:0]      extent;
	logic                  result_valid;
	logic [CH_W-1:0]       red_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       blue_out;
	logic                  done_res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// frame model and what the block's memory actually holds
	logic [COLOR_W-1:0] frame_model [0:FRAME_W*FRAME_H-1];
	bit                 loaded [0:FRAME_W*FRAME_H-1];
	int                 recent_writes[$];
	logic [CFG_DATA_W-1:0] img_w;
	logic [CFG_DATA_W-1:0] img_h;

	pixel_reply_t expected_px[$];
	int  errors;
	int  n_cmd [4];
	int  n_results;
	int  cfg_writes;
	bit  idle_on;

	rgb_frame_disc_cross_drawer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.row(row), .col(col), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.extent(extent), .result_valid(result_valid), .red_out(red_out),
		.green_out(green_out), .blue_out(blue_out), .done_res(done_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_w();
		return (img_w > FRAME_W) ? FRAME_W : int'(img_w);
	endfunction

	function automatic int eff_h();
		return (img_h > FRAME_H) ? FRAME_H : int'(img_h);
	endfunction

	function automatic bit in_image(int r, int c);
		return r >= 0 && r < eff_h() && c >= 0 && c < eff_w();
	endfunction

	function automatic void plot(int r, int c, logic [COLOR_W-1:0] color, bit note);
		int a;
		if (!in_image(r, c))
			return;
		a = r * FRAME_W + c;
		frame_model[a] = color;
		loaded[a] = 1'b1;
		if (note) begin
			recent_writes.push_back(a);
			if (recent_writes.size() > 64)
				void'(recent_writes.pop_front());
		end
	endfunction

	// update the frame model for one accepted command and return its reply
	function automatic pixel_reply_t predict_frame(cmd_t k, int r, int c,
			logic [COLOR_W-1:0] color, int ext);
		pixel_reply_t rep;
		logic [COLOR_W-1:0] px;
		int e;
		px = '0;
		case (k)
			CMD_WRITE: plot(r, c, color, 1'b1);
			CMD_READ: begin
				if (in_image(r, c))
					px = frame_model[r * FRAME_W + c];
			end
			CMD_DISC: begin
				e = ext + 1;
				for (int i = -e; i <= e; i++)
					for (int j = -e; j <= e; j++)
						if (i * i + j * j < e * e)
							plot(r + i, c + j, color, 1'b0);
			end
			default: begin
				for (int i = -ext; i <= ext; i++)
					plot(r + i, c, color, 1'b0);
				for (int i = -ext; i <= ext; i++)
					plot(r, c + i, color, 1'b0);
			end
		endcase
		rep.red = px[23:16];
		rep.green = px[15:8];
		rep.blue = px[7:0];
		rep.done = 1'b1;
		return rep;
	endfunction

	task automatic send_command(cmd_t k, int r, int c, logic [COLOR_W-1:0] color, int ext);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 34) begin
			gap = $urandom_range(4, 1);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		command = k;
		row = r[COORD_W-1:0];
		col = c[COORD_W-1:0];
		red_in = color[23:16];
		green_in = color[15:8];
		blue_in = color[7:0];
		extent = ext[EXT_W-1:0];
		do @(posedge clk); while (busy);
		expected_px.push_back(predict_frame(k, r, c, color, ext));
		n_cmd[k]++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH)
			img_w = val[CFG_DATA_W-1:0];
		else if (idx == REG_IMAGE_HEIGHT)
			img_h = val[CFG_DATA_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_dims(int w, int h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic logic [COLOR_W-1:0] rand_color();
		return COLOR_W'($urandom);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(2047)) - 1024;
	endfunction

	// read target: mostly a loaded in-image pixel when one is found, else outside the image
	task automatic pick_read(output int r, output int c);
		int a;
		if ($urandom_range(9) != 0 && eff_w() > 0 && eff_h() > 0) begin
			for (int t = 0; t < 8; t++) begin
				r = $urandom_range(eff_h() - 1);
				c = $urandom_range(eff_w() - 1);
				if (loaded[r * FRAME_W + c])
					return;
			end
			for (int t = recent_writes.size() - 1; t >= 0; t--) begin
				a = recent_writes[t];
				if (in_image(a / FRAME_W, a % FRAME_W)) begin
					r = a / FRAME_W;
					c = a % FRAME_W;
					return;
				end
			end
		end
		do begin
			r = any_coord();
			c = any_coord();
		end while (in_image(r, c));
	endtask

	task automatic random_command();
		int p, r, c, ext;
		cmd_t k;
		p = $urandom_range(99);
		k = (p < 35) ? CMD_WRITE : (p < 65) ? CMD_READ : (p < 85) ? CMD_DISC : CMD_CROSS;
		ext = 0;
		if (k == CMD_READ) begin
			pick_read(r, c);
		end else if ($urandom_range(9) < 8) begin
			r = int'($urandom_range(eff_h() + (k == CMD_WRITE ? 0 : 39))) -
				(k == CMD_WRITE ? 0 : 20);
			c = int'($urandom_range(eff_w() + (k == CMD_WRITE ? 0 : 39))) -
				(k == CMD_WRITE ? 0 : 20);
		end else begin
			r = any_coord();
			c = any_coord();
		end
		if (k == CMD_DISC) begin
			p = $urandom_range(99);
			ext = (p < 70) ? $urandom_range(7) : (p < 96) ? $urandom_range(15, 8) :
				$urandom_range(40, 16);
		end else if (k == CMD_CROSS) begin
			ext = ($urandom_range(9) < 3) ? $urandom_range(255) : $urandom_range(15);
		end else if (k != CMD_READ) begin
			ext = $urandom_range(255);
		end else begin
			ext = $urandom_range(255);
		end
		send_command(k, r, c, rand_color(), ext);
	endtask

	task automatic test_pixel_access();
		send_command(CMD_WRITE, 0, 0, 24'h000000, 0);
		send_command(CMD_WRITE, 255, 255, 24'hffffff, 255);
		send_command(CMD_WRITE, 0, 255, 24'h5aa5c3, 0);
		send_command(CMD_WRITE, -1024, 1023, 24'h123456, 0);
		send_command(CMD_WRITE, -1, 0, 24'hfedcba, 0);
		send_command(CMD_READ, 0, 0, 24'hffffff, 0);
		send_command(CMD_READ, 255, 255, 24'h000000, 0);
		send_command(CMD_READ, 0, 255, 24'h000000, 0);
		send_command(CMD_READ, -1024, -1024, 24'h000000, 0);
		send_command(CMD_READ, 1023, 256, 24'h000000, 0);
	endtask

	task automatic test_shapes();
		send_command(CMD_DISC, 10, 10, 24'h0f0f0f, 0);
		send_command(CMD_READ, 10, 10, 24'h000000, 0);
		send_command(CMD_DISC, 128, 128, 24'h80ff01, 255);
		send_command(CMD_DISC, -1024, -1024, 24'hffffff, 5);
		send_command(CMD_CROSS, 0, 0, 24'h3c3c3c, 255);
		send_command(CMD_CROSS, 1023, 1023, 24'hc3c3c3, 3);
		send_command(CMD_CROSS, 254, 1, 24'h010203, 2);
		send_command(CMD_READ, 254, 0, 24'h000000, 0);
		send_command(CMD_READ, 200, 0, 24'h000000, 0);
	endtask

	task automatic test_image_limits();
		set_dims(0, 0);
		send_command(CMD_WRITE, 0, 0, 24'hffffff, 0);
		send_command(CMD_DISC, 0, 0, 24'hffffff, 3);
		send_command(CMD_READ, 0, 0, 24'h000000, 0);
		set_dims(1, 1);
		send_command(CMD_CROSS, 0, 0, 24'habcdef, 4);
		send_command(CMD_READ, 0, 0, 24'h000000, 0);
		send_command(CMD_READ, 0, 1, 24'h000000, 0);
		set_dims(511, 511);
		write_reg(REG_SPARE_LO, 0);
		write_reg(REG_SPARE_HI, 511);
		send_command(CMD_WRITE, 255, 0, 24'h777777, 0);
		send_command(CMD_READ, 255, 0, 24'h000000, 0);
		send_command(CMD_READ, 256, 0, 24'h000000, 0);
	endtask

	task automatic test_random(int items);
		int widths [7] = '{256, 511, 1, 256, 37, 0, 0};
		int heights [7] = '{256, 300, 256, 1, 12, 5, 0};
		int per;
		per = items / 7;
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 6) begin
				widths[ph] = $urandom_range(256, 1);
				heights[ph] = $urandom_range(256, 1);
			end
			set_dims(widths[ph], heights[ph]);
			idle_on = (ph != 3);
			repeat (per) random_command();
		end
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		pixel_reply_t want;
		if (arst_n && result_valid === 1'b1) begin
			n_results++;
			if (expected_px.size() == 0) begin
				$error("result word with no command outstanding");
				errors++;
			end else begin
				want = expected_px.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %0h, got %0h", want.red, red_out);
					errors++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0h, got %0h", want.green, green_out);
					errors++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0h, got %0h", want.blue, blue_out);
					errors++;
				end
				if (done_res !== want.done) begin
					$error("done_res: expected %0b, got %0b", want.done, done_res);
					errors++;
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("timeout with %0d result words outstanding", expected_px.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		errors = 0;
		n_results = 0;
		cfg_writes = 0;
		idle_on = 1'b1;
		n_cmd = '{0, 0, 0, 0};
		img_w = RST_DIM;
		img_h = RST_DIM;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_WRITE;
		row = '0;
		col = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		extent = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_pixel_access();
		test_shapes();
		test_image_limits();
		test_random(550);

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_px.size() != 0) begin
			$error("%0d result words never arrived", expected_px.size());
			errors++;
		end
		$display("commands: %0d write, %0d read, %0d disc, %0d cross; %0d results checked",
			n_cmd[CMD_WRITE], n_cmd[CMD_READ], n_cmd[CMD_DISC], n_cmd[CMD_CROSS],
			n_results);
		$display("%0d register writes over image sizes from 0x0 to oversized; %0d errors",
			cfg_writes, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rfdcd_pkg.sv
rtl/rfdcd_front.sv
rtl/rfdcd_fifo.sv
rtl/rfdcd_back.sv
rtl/rgb_frame_disc_cross_drawer.sv
dv/rgb_frame_disc_cross_drawer_test.sv
